### hdl/dpcm_pixel_predictive_coder_assert.svh
// Assertion macros for the DPCM coder checker.
`ifndef DPCM_PIXEL_PREDICTIVE_CODER_ASSERT_SVH
`define DPCM_PIXEL_PREDICTIVE_CODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DPCM_ASSERT_IMPL(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define DPCM_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

### hdl/dpcm_pkg.sv
package dpcm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int SIZE_W  = 11;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int LEVELS  = 256;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic              MODE_ENCODE  = 1'b0;
  localparam logic [SIZE_W-1:0] WIDTH_RST    = 11'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RST   = 11'd1024;

  localparam logic [7:0] EMPTY_PRED = 8'((LEVELS - 1) / 2);
  // floor(s/3) == (s*683) >> 11 for s <= 765
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sample_out;
    logic       end_of_row;
    logic       end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic x_nz;
    logic y_nz;
    logic ur_in;
    logic mode;
  } pred_ctl_t;

endpackage

### hdl/dpcm_stream_if.sv
interface dpcm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/dpcm_apb_regs.sv
module dpcm_apb_regs
  import dpcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] index;
  logic       wr;

  assign index  = paddr[3:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_ENCODE;
      cfg.image_width  <= WIDTH_RST;
      cfg.image_height <= HEIGHT_RST;
    end else if (wr) begin
      case (index)
        REG_MODE:   cfg.mode         <= pwdata[0];
        REG_WIDTH:  cfg.image_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: cfg.image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (index)
      REG_MODE:   prdata = DATA_W'(cfg.mode);
      REG_WIDTH:  prdata = DATA_W'(cfg.image_width);
      REG_HEIGHT: prdata = DATA_W'(cfg.image_height);
      default:    prdata = '0;
    endcase
  end

endmodule

### hdl/dpcm_row_ram.sv
module dpcm_row_ram
  import dpcm_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/dpcm_predictor.sv
module dpcm_predictor
  import dpcm_pkg::*;
(
  input  pred_ctl_t  ctl,
  input  logic [7:0] left_px,
  input  logic [7:0] ul_px,
  input  logic [7:0] up_px,
  input  logic [7:0] ur_px,
  input  logic [7:0] sample,
  output logic [7:0] result,
  output logic [7:0] pixel
);

  logic [9:0]  sum;
  logic [2:0]  count;
  logic [19:0] prod;
  logic [7:0]  pred;

  always_comb begin
    sum   = '0;
    count = '0;
    if (ctl.x_nz) begin
      sum   = sum + 10'(left_px);
      count = count + 3'd1;
    end
    if (ctl.x_nz && ctl.y_nz) begin
      sum   = sum + 10'(ul_px);
      count = count + 3'd1;
    end
    if (ctl.y_nz) begin
      sum   = sum + 10'(up_px);
      count = count + 3'd1;
    end
    if (ctl.y_nz && ctl.ur_in) begin
      sum   = sum + 10'(ur_px);
      count = count + 3'd1;
    end
  end

  assign prod = sum * DIV3_MUL;

  always_comb begin
    case (count)
      3'd1:    pred = sum[7:0];
      3'd2:    pred = sum[8:1];
      3'd3:    pred = prod[DIV3_SHIFT+7:DIV3_SHIFT];
      3'd4:    pred = sum[9:2];
      default: pred = EMPTY_PRED;
    endcase
  end

  assign result = pred - sample;
  assign pixel  = (ctl.mode == MODE_ENCODE) ? sample : result;

endmodule

### hdl/dpcm_pixel_predictive_coder.sv
// Results are registered: a result is presented in the cycle after its request is accepted.
// Throughput: one request per clock, back to back, unless the output stalls;
// the row store has one write port and one read port, and the upper-right
// pixel is fetched one request ahead through the registered read port.
// Reset: counters, neighbor registers and output valid clear; registers return
// to encode mode, 1024 x 1024. The row store is not cleared.
module dpcm_pixel_predictive_coder
  import dpcm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  dpcm_stream_if.sink       in_stream,
  dpcm_stream_if.source     out_stream,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = CW + 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RW1 = RW + 1;

  cfg_t       cfg;
  pred_ctl_t  ctl;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [7:0]    left_px;
  logic [7:0]    ul_px;
  logic [7:0]    up_px;
  logic [7:0]    first_px;
  logic          fwd_ur;

  logic [CW1-1:0] w_eff;
  logic [RW1-1:0] h_eff;
  logic [CW1-1:0] x_inc;
  logic [RW1-1:0] y_inc;
  logic [CW-1:0]  col_next;
  logic [CW1-1:0] rd_addr;
  logic           eor;
  logic           eof;
  logic           accept;

  logic [7:0] ram_rdata;
  logic [7:0] ur_px;
  logic [7:0] up_next;
  logic [7:0] result;
  logic [7:0] pixel;

  dpcm_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = CW1'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = CW1'(MAX_WIDTH);
    end else begin
      w_eff = CW1'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_eff = RW1'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h_eff = RW1'(MAX_HEIGHT);
    end else begin
      h_eff = RW1'(cfg.image_height);
    end
  end

  assign in_stream.ready = !out_stream.valid || out_stream.ready;
  assign accept          = in_stream.valid && in_stream.ready;

  assign x_inc    = {1'b0, col} + CW1'(1);
  assign y_inc    = {1'b0, row} + RW1'(1);
  assign eor      = x_inc >= w_eff;
  assign eof      = eor && (y_inc >= h_eff);
  assign col_next = eor ? '0 : x_inc[CW-1:0];
  assign rd_addr  = {1'b0, col_next} + CW1'(1);

  // upper-right was read one request ahead; same-cycle write is forwarded
  assign ur_px = fwd_ur ? left_px : ram_rdata;

  assign ctl.x_nz  = col != '0;
  assign ctl.y_nz  = row != '0;
  assign ctl.ur_in = !eor;
  assign ctl.mode  = cfg.mode;

  dpcm_predictor u_pred (
    .ctl     (ctl),
    .left_px (left_px),
    .ul_px   (ul_px),
    .up_px   (up_px),
    .ur_px   (ur_px),
    .sample  (in_stream.data.sample_in),
    .result  (result),
    .pixel   (pixel)
  );

  dpcm_row_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (pixel),
    .re    (accept && (rd_addr < CW1'(MAX_WIDTH))),
    .raddr (rd_addr[CW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (!eor) begin
      up_next = ur_px;
    end else if (col == '0) begin
      up_next = pixel;
    end else begin
      up_next = first_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      left_px <= '0;
      ul_px   <= '0;
      up_px   <= '0;
      fwd_ur  <= 1'b0;
    end else if (accept) begin
      col     <= col_next;
      row     <= eof ? '0 : (eor ? y_inc[RW-1:0] : row);
      left_px <= pixel;
      ul_px   <= up_px;
      up_px   <= up_next;
      fwd_ur  <= rd_addr == {1'b0, col};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (col == '0)) begin
      first_px <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stream.valid <= 1'b0;
    end else if (in_stream.ready) begin
      out_stream.valid <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_stream.data.sample_out   <= result;
      out_stream.data.end_of_row   <= eor;
      out_stream.data.end_of_frame <= eof;
    end
  end

endmodule

### hdl/dpcm_checker.sv
`include "dpcm_pixel_predictive_coder_assert.svh"

module dpcm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] sample_out,
  input logic       end_of_row,
  input logic       end_of_frame
);

  `DPCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(end_of_row) && $stable(end_of_frame), "stalled result changed")
  `DPCM_ASSERT_IMPL(a_eof_eor, out_valid && end_of_frame, end_of_row, "frame end without row end")
  `DPCM_ASSERT_IMPL(a_ready_free, !out_valid, in_ready, "not ready with empty output")
  `DPCM_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "accepted request gave no result")

endmodule

bind dpcm_pixel_predictive_coder dpcm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_stream.valid),
  .in_ready     (in_stream.ready),
  .out_valid    (out_stream.valid),
  .out_ready    (out_stream.ready),
  .sample_out   (out_stream.data.sample_out),
  .end_of_row   (out_stream.data.end_of_row),
  .end_of_frame (out_stream.data.end_of_frame)
);
